>>> hdl/attentional_evidence_race_step_unit_macros.svh
// ----------------------------------------------------------------------------
// attentional evidence race step unit: assertion macros
// shared concurrent assertion forms, clocked on clk and quiet during rst
// ----------------------------------------------------------------------------
`ifndef ATTENTIONAL_EVIDENCE_RACE_STEP_UNIT_MACROS_SVH
`define ATTENTIONAL_EVIDENCE_RACE_STEP_UNIT_MACROS_SVH

// same-cycle implication
`define AERS_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define AERS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

>>> hdl/aers_pkg.sv
// ----------------------------------------------------------------------------
// aers_pkg
// shared types and constants of the attentional evidence race step unit
// ----------------------------------------------------------------------------
`default_nettype none

package aers_pkg;

  // race size and field widths
  localparam int ITEMS       = 4;
  localparam int IDX_W       = (ITEMS > 1) ? $clog2(ITEMS) : 1;
  localparam int RATE_REGS   = 4;
  localparam int FIX_W       = 2;
  localparam int SAMPLE_W    = 16;
  localparam int RATE_W      = 16;
  localparam int THETA_W     = 13;
  localparam int SCALE_W     = 16;
  localparam int STEP_W      = 10;
  localparam int MAXDUR_W    = 16;
  localparam int EV_W        = 32;
  localparam int ELAPSED_W   = 20;
  localparam int FRAC_BITS   = 12;
  localparam int DRIFT_W     = 17;
  localparam int NOISE_W     = 21;
  localparam int ONE_Q12     = 4096;
  localparam int LEAD_MIN    = 4096;

  // configuration port
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;

  // register reset values
  localparam logic [THETA_W-1:0]  THETA_RESET  = THETA_W'(ONE_Q12);
  localparam logic [STEP_W-1:0]   STEP_RESET   = STEP_W'(10);
  localparam logic [MAXDUR_W-1:0] MAXDUR_RESET = MAXDUR_W'(10000);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RATE_0       = 4'd0,
    REG_RATE_1       = 4'd1,
    REG_RATE_2       = 4'd2,
    REG_RATE_3       = 4'd3,
    REG_THETA        = 4'd4,
    REG_NOISE_SCALE  = 4'd5,
    REG_TIME_STEP    = 4'd6,
    REG_MAX_DURATION = 4'd7
  } cfg_reg_t;

  typedef logic [EV_W-1:0] ev_t;

  typedef struct packed {
    logic [RATE_REGS-1:0][RATE_W-1:0] rate;
    logic [THETA_W-1:0]               theta;
    logic [SCALE_W-1:0]               noise_scale;
    logic [STEP_W-1:0]                time_step;
    logic [MAXDUR_W-1:0]              max_duration;
  } cfg_t;

  typedef struct packed {
    logic                       start_trial;
    logic [FIX_W-1:0]           fixated_item;
    logic signed [SAMPLE_W-1:0] noise_0;
    logic signed [SAMPLE_W-1:0] noise_1;
    logic signed [SAMPLE_W-1:0] noise_2;
    logic signed [SAMPLE_W-1:0] noise_3;
  } in_word_t;

  typedef struct packed {
    logic                 finished;
    logic                 decided;
    logic [FIX_W-1:0]     choice;
    logic [ELAPSED_W-1:0] response_time;
  } out_word_t;

  // per-lane control from the pipeline sequencing
  typedef struct packed {
    logic s1_en;
    logic s1_hit;
    logic s2_en;
    logic s2_start;
    logic s2_proc;
    logic s2_hit;
  } lane_ctl_t;

  // merge stage status back to the pipeline
  typedef struct packed {
    logic done;
    logic take;
  } merge_stat_t;

endpackage

`default_nettype wire

>>> hdl/aers_cfg.sv
// ----------------------------------------------------------------------------
// aers_cfg
// configuration register file, theta clamped to one on write
// ----------------------------------------------------------------------------
`default_nettype none

module aers_cfg
  import aers_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   wr_en,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                        cfg
);

  logic [THETA_W-1:0] theta_clamped;

  // values above one are used as one
  always_comb begin
    if (cfg_data[THETA_W-1:0] > THETA_W'(ONE_Q12)) begin
      theta_clamped = THETA_W'(ONE_Q12);
    end else begin
      theta_clamped = cfg_data[THETA_W-1:0];
    end
  end

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rate         <= '0;
      cfg.theta        <= THETA_RESET;
      cfg.noise_scale  <= '0;
      cfg.time_step    <= STEP_RESET;
      cfg.max_duration <= MAXDUR_RESET;
    end else if (wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_RATE_0:       cfg.rate[0]          <= cfg_data[RATE_W-1:0];
        REG_RATE_1:       cfg.rate[1]          <= cfg_data[RATE_W-1:0];
        REG_RATE_2:       cfg.rate[2]          <= cfg_data[RATE_W-1:0];
        REG_RATE_3:       cfg.rate[3]          <= cfg_data[RATE_W-1:0];
        REG_THETA:        cfg.theta            <= theta_clamped;
        REG_NOISE_SCALE:  cfg.noise_scale      <= cfg_data[SCALE_W-1:0];
        REG_TIME_STEP:    cfg.time_step        <= cfg_data[STEP_W-1:0];
        REG_MAX_DURATION: cfg.max_duration     <= cfg_data[MAXDUR_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/aers_lane.sv
// ----------------------------------------------------------------------------
// aers_lane
// one item of the race: drift and noise products, then evidence accumulator
// ----------------------------------------------------------------------------
`default_nettype none

module aers_lane
  import aers_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  lane_ctl_t                       ctl,
  input  wire logic signed [RATE_W-1:0]   rate,
  input  wire logic [THETA_W-1:0]         theta,
  input  wire logic [SCALE_W-1:0]         noise_scale,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  output ev_t                             evidence
);

  localparam int DPROD_W = RATE_W + THETA_W + 1;
  localparam int NPROD_W = SCALE_W + SAMPLE_W + 1;
  localparam int SUM_W   = EV_W + 2;

  logic signed [DPROD_W-1:0] drift_prod;
  logic signed [DPROD_W-1:0] drift_rnd;
  logic signed [NPROD_W-1:0] noise_prod;
  logic signed [NPROD_W-1:0] noise_rnd;
  logic signed [DRIFT_W-1:0] drift_sel;

  logic signed [DRIFT_W-1:0] drift;
  logic signed [NOISE_W-1:0] noise;
  logic                      seen;

  logic [EV_W-1:0]           base;
  logic                      seen_next;
  logic signed [SUM_W-1:0]   sum;
  logic                      ovf_hi;
  logic                      ovf_lo;
  logic [EV_W-1:0]           sum_sat;
  logic [EV_W-1:0]           evidence_next;

  // stage 1: rate times theta (the fixated item takes the rate as is) and scale times sample, rounded half up
  always_comb begin
    drift_prod = rate * $signed({1'b0, theta});
    drift_rnd  = drift_prod + DPROD_W'(1 << (FRAC_BITS - 1));
    noise_prod = $signed({1'b0, noise_scale}) * sample;
    noise_rnd  = noise_prod + NPROD_W'(1 << (FRAC_BITS - 1));
    if (ctl.s1_hit) begin
      drift_sel = DRIFT_W'(rate);
    end else begin
      drift_sel = drift_rnd[FRAC_BITS+DRIFT_W-1:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s1_en) begin
      drift <= drift_sel;
      noise <= noise_rnd[FRAC_BITS+NOISE_W-1:FRAC_BITS];
    end
  end

  // stage 2: clear on trial start, mark fixation, accumulate with saturation
  always_comb begin
    base      = ctl.s2_start ? '0 : evidence;
    seen_next = (seen & !ctl.s2_start) | ctl.s2_hit;
    sum       = SUM_W'($signed(base)) + SUM_W'(drift) + SUM_W'(noise);
    ovf_hi    = !sum[SUM_W-1] && (|sum[SUM_W-2:EV_W-1]);
    ovf_lo    = sum[SUM_W-1] && !(&sum[SUM_W-2:EV_W-1]);
    if (ovf_hi) begin
      sum_sat = {1'b0, {(EV_W-1){1'b1}}};
    end else if (ovf_lo) begin
      sum_sat = {1'b1, {(EV_W-1){1'b0}}};
    end else begin
      sum_sat = sum[EV_W-1:0];
    end
    evidence_next = seen_next ? sum_sat : base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      evidence <= '0;
      seen     <= 1'b0;
    end else if (ctl.s2_en && ctl.s2_proc) begin
      evidence <= evidence_next;
      seen     <= seen_next;
    end
  end

  `include "attentional_evidence_race_step_unit_macros.svh"

  // an item never seen this trial holds no evidence
  `AERS_ASSERT_IMPL(a_unseen_is_zero, !seen, evidence == '0, "unseen item has evidence")

endmodule

`default_nettype wire

>>> hdl/aers_merge.sv
// ----------------------------------------------------------------------------
// aers_merge
// leader search, lead test and finish flag over all lanes, result register
// ----------------------------------------------------------------------------
`default_nettype none

module aers_merge
  import aers_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  ev_t [ITEMS-1:0]           evidence,
  input  wire logic [ELAPSED_W-1:0] elapsed,
  input  wire logic [MAXDUR_W-1:0]  max_duration,
  input  wire logic                 m_valid,
  input  wire logic                 m_proc,
  input  wire logic                 result_stall,
  output merge_stat_t               stat,
  output logic                      result_valid,
  output out_word_t                 result
);

  logic [ITEMS-1:0] gt    [ITEMS];
  logic [ITEMS-1:0] ahead [ITEMS];
  logic [ITEMS-1:0] is_max;
  logic [IDX_W-1:0] leader;
  logic [IDX_W-1:0] leader_next;
  logic             decided;
  logic             timeout;
  logic             done_flag;
  logic             done_next;
  logic             take;

  // pairwise compare and lead distance, all lanes at once
  always_comb begin
    logic signed [EV_W:0] diff;
    for (int i = 0; i < ITEMS; i++) begin
      for (int j = 0; j < ITEMS; j++) begin
        diff        = (EV_W+1)'($signed(evidence[i])) - (EV_W+1)'($signed(evidence[j]));
        gt[i][j]    = $signed(evidence[i]) > $signed(evidence[j]);
        ahead[i][j] = diff >= (EV_W+1)'(LEAD_MIN);
      end
    end
  end

  // an item is a maximum when nobody beats it
  always_comb begin
    for (int i = 0; i < ITEMS; i++) begin
      is_max[i] = 1'b1;
      for (int j = 0; j < ITEMS; j++) begin
        if (gt[j][i]) begin
          is_max[i] = 1'b0;
        end
      end
    end
  end

  // leader holds on ties, otherwise the lowest index at the top
  always_comb begin
    leader_next = leader;
    if (!is_max[leader]) begin
      for (int i = ITEMS - 1; i >= 0; i--) begin
        if (is_max[i]) begin
          leader_next = IDX_W'(i);
        end
      end
    end
  end

  // lead test against every other item
  always_comb begin
    decided = 1'b1;
    for (int k = 0; k < ITEMS; k++) begin
      if (IDX_W'(k) != leader_next && !ahead[leader_next][k]) begin
        decided = 1'b0;
      end
    end
  end

  // finish flag as seen by the word now leaving the state stage
  assign timeout   = elapsed > ELAPSED_W'(max_duration);
  assign done_next = (m_valid && m_proc) ? (decided || timeout) : done_flag;
  assign take      = m_valid && (!result_valid || !result_stall);
  assign stat.done = done_next;
  assign stat.take = take;

  // result register and trial flags
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      leader       <= '0;
      done_flag    <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
      leader       <= leader_next;
      done_flag    <= done_next;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.finished      <= done_next;
      result.decided       <= decided;
      result.choice        <= FIX_W'(leader_next);
      result.response_time <= elapsed;
    end
  end

  `include "attentional_evidence_race_step_unit_macros.svh"

  // a frozen tick only follows a finished trial
  `AERS_ASSERT_IMPL(a_frozen_after_done, m_valid && !m_proc, done_flag, "frozen tick while running")
  // a finished word carries a decision, a timeout or an earlier finish of its trial
  `AERS_ASSERT_IMPL(a_finish_cause, take && done_next, decided || timeout || done_flag, "finish without cause")

endmodule

`default_nettype wire

>>> hdl/attentional_evidence_race_step_unit.sv
// ----------------------------------------------------------------------------
// attentional_evidence_race_step_unit
// one tick of a multi-item attentional evidence race per accepted word
// ----------------------------------------------------------------------------
// Takes one tick word per clock while the result side does not stall, and
// returns one result word per tick. Each tick passes through the lane product
// stage (drift and noise multipliers per item), the lane accumulator stage
// (saturating evidence update) and the merge stage (leader search, lead test,
// finish flag), which registers the result. The one-tick rate is set by the
// loop from the evidence registers through the merge comparators and the
// finish flag back to the accumulator enables, which is combinational.
// Configuration is written through the cfg port at any time (cfg_ready is
// always high) and is meant to change only while no tick is in flight.
`default_nettype none

module attentional_evidence_race_step_unit
  import aers_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   item_valid,
  output logic                        item_stall,
  input  in_word_t                    item,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output out_word_t                   result,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t                               cfg;
  merge_stat_t                        stat;
  lane_ctl_t [ITEMS-1:0]              lane_ctl;
  ev_t [ITEMS-1:0]                    evidence;
  logic [RATE_REGS-1:0][SAMPLE_W-1:0] samples;

  logic                  s1_en;
  logic                  s2_en;
  logic                  s2_proc;
  logic                  v1;
  logic                  v2;
  logic                  v2_proc;
  logic                  s1_start;
  logic [FIX_W-1:0]      s1_fix;
  logic [ELAPSED_W-1:0]  elapsed;
  logic [ELAPSED_W-1:0]  elapsed_base;
  logic [ELAPSED_W:0]    elapsed_sum;
  logic [ELAPSED_W-1:0]  elapsed_next;

  // configuration registers
  assign cfg_ready = 1'b1;

  aers_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // pipeline handshakes
  assign s2_en      = v1 && (!v2 || stat.take);
  assign s1_en      = item_valid && !item_stall;
  assign item_stall = v1 && !s2_en;
  assign s2_proc    = s1_start || !stat.done;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v2_proc <= 1'b0;
    end else begin
      if (s1_en) begin
        v1 <= 1'b1;
      end else if (s2_en) begin
        v1 <= 1'b0;
      end
      if (s2_en) begin
        v2      <= 1'b1;
        v2_proc <= s2_proc;
      end else if (stat.take) begin
        v2 <= 1'b0;
      end
    end
  end

  // tick flags travel with the word
  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_start <= item.start_trial;
      s1_fix   <= item.fixated_item;
    end
  end

  // elapsed time, cleared on trial start, saturating
  always_comb begin
    elapsed_base = s1_start ? '0 : elapsed;
    elapsed_sum  = (ELAPSED_W+1)'(elapsed_base) + (ELAPSED_W+1)'(cfg.time_step);
    if (elapsed_sum[ELAPSED_W]) begin
      elapsed_next = '1;
    end else begin
      elapsed_next = elapsed_sum[ELAPSED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed <= '0;
    end else if (s2_en && s2_proc) begin
      elapsed <= elapsed_next;
    end
  end

  // noise samples per lane
  assign samples = {item.noise_3, item.noise_2, item.noise_1, item.noise_0};

  // item lanes
  for (genvar i = 0; i < ITEMS; i++) begin : g_lane
    logic signed [RATE_W-1:0]   lane_rate;
    logic signed [SAMPLE_W-1:0] lane_sample;

    if (i < RATE_REGS) begin : g_reg
      assign lane_rate   = cfg.rate[i];
      assign lane_sample = samples[i];
    end else begin : g_none
      assign lane_rate   = '0;
      assign lane_sample = '0;
    end

    assign lane_ctl[i].s1_en    = s1_en;
    assign lane_ctl[i].s1_hit   = int'(item.fixated_item) == i;
    assign lane_ctl[i].s2_en    = s2_en;
    assign lane_ctl[i].s2_start = s1_start;
    assign lane_ctl[i].s2_proc  = s2_proc;
    assign lane_ctl[i].s2_hit   = int'(s1_fix) == i;

    aers_lane u_lane (
      .clk         (clk),
      .rst         (rst),
      .ctl         (lane_ctl[i]),
      .rate        (lane_rate),
      .theta       (cfg.theta),
      .noise_scale (cfg.noise_scale),
      .sample      (lane_sample),
      .evidence    (evidence[i])
    );
  end

  // leader, lead test and result register
  aers_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .evidence     (evidence),
    .elapsed      (elapsed),
    .max_duration (cfg.max_duration),
    .m_valid      (v2),
    .m_proc       (v2_proc),
    .result_stall (result_stall),
    .stat         (stat),
    .result_valid (result_valid),
    .result       (result)
  );

  `include "attentional_evidence_race_step_unit_macros.svh"

  // a frozen tick leaves the clock alone
  `AERS_ASSERT_NEXT(a_frozen_time, s2_en && !s2_proc, elapsed == $past(elapsed), "time moved on frozen tick")
  // within a trial time never runs backward
  `AERS_ASSERT_NEXT(a_time_monotonic, s2_en && !s1_start, elapsed >= $past(elapsed), "time went backward")

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives tick words into the attentional evidence race step unit with random
// input gaps and result stalls and checks every result word, field by field,
// against an in-bench model of the race (evidence, seen flags, leader, time, finish).
// ----------------------------------------------------------------------------
module testbench;
  import aers_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 6;
  localparam int SAT_TICKS    = 30;

  localparam longint EV_HI       = (longint'(1) <<< (EV_W - 1)) - 1;
  localparam longint EV_LO       = -(longint'(1) <<< (EV_W - 1));
  localparam longint ELAPSED_TOP = (longint'(1) <<< ELAPSED_W) - 1;

  localparam logic [CFG_INDEX_W-1:0]    REG_UNUSED = '1;
  localparam logic signed [RATE_W-1:0]  RATE_MAX   = 16'sh7fff;
  localparam logic signed [RATE_W-1:0]  RATE_MIN   = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] SMP_MAX   = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SMP_MIN   = 16'sh8000;

  // block ports
  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   item_valid   = 1'b0;
  logic                   item_stall;
  in_word_t               item         = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  out_word_t              result;
  logic                   cfg_valid    = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;

  // race model: registers and trial state
  logic signed [RATE_W-1:0] rate_q [RATE_REGS] = '{default: '0};
  logic [THETA_W-1:0]       theta_q            = THETA_RESET;
  logic [SCALE_W-1:0]       noise_scale_q      = '0;
  logic [STEP_W-1:0]        time_step_q        = STEP_RESET;
  logic [MAXDUR_W-1:0]      max_duration_q     = MAXDUR_RESET;
  logic signed [EV_W-1:0]   evidence_q [ITEMS] = '{default: '0};
  logic                     seen_q [ITEMS]     = '{default: 1'b0};
  logic [IDX_W-1:0]         leader_q           = '0;
  logic [ELAPSED_W-1:0]     elapsed_q          = '0;
  logic                     done_q             = 1'b0;
  out_word_t                race_expected [$];

  // run control and tallies
  bit idle_on         = 1'b1;
  int hold_cycles     = 0;
  int stall_burst     = 0;
  int cycle_count     = 0;
  int held_off_cycles = 0;
  int fail_count      = 0;
  int ticks_sent      = 0;
  int trials_started  = 0;
  int results_checked = 0;

  attentional_evidence_race_step_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // cycle limit and input backpressure tally
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (item_valid && item_stall) held_off_cycles <= held_off_cycles + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side stall: long hold on request, else short random bursts
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      result_stall <= 1'b1;
      hold_cycles  <= hold_cycles - 1;
    end else if (stall_burst > 0) begin
      result_stall <= 1'b1;
      stall_burst  <= stall_burst - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      result_stall <= 1'b1;
      stall_burst  <= $urandom_range(0, 2);
    end else begin
      result_stall <= 1'b0;
    end
  end

  // compare each accepted result word with the oldest prediction
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && result_valid && !result_stall) begin
      if (race_expected.size() == 0) begin
        $error("result word with no tick pending: %p", result);
        fail_count++;
      end else begin
        want = race_expected.pop_front();
        results_checked++;
        if (result.finished !== want.finished) begin
          $error("finished: expected %0d, got %0d", want.finished, result.finished);
          fail_count++;
        end
        if (result.decided !== want.decided) begin
          $error("decided: expected %0d, got %0d", want.decided, result.decided);
          fail_count++;
        end
        if (result.choice !== want.choice) begin
          $error("choice: expected %0d, got %0d", want.choice, result.choice);
          fail_count++;
        end
        if (result.response_time !== want.response_time) begin
          $error("response_time: expected %0d, got %0d",
                 want.response_time, result.response_time);
          fail_count++;
        end
      end
    end
  end

  // floor((x + 2048) / 4096): x rounded half up out of Q.12
  function automatic longint round_q12(input longint x);
    return (x + (ONE_Q12 / 2)) >>> FRAC_BITS;
  endfunction

  // leader ahead of every other item by at least one
  function automatic bit lead_held();
    int k;
    for (k = 0; k < ITEMS; k++) begin
      if (k != leader_q &&
          longint'(evidence_q[leader_q]) - longint'(evidence_q[k]) < LEAD_MIN)
        return 1'b0;
    end
    return 1'b1;
  endfunction

  // advance the race model by one tick and queue the expected result
  task automatic predict_tick(input in_word_t w);
    logic signed [SAMPLE_W-1:0] smp [ITEMS];
    longint theta_eff, drift, noise, acc;
    bit decided_now;
    out_word_t o;
    int k;
    smp[0] = w.noise_0;
    smp[1] = w.noise_1;
    smp[2] = w.noise_2;
    smp[3] = w.noise_3;
    if (w.start_trial) begin
      trials_started++;
      for (k = 0; k < ITEMS; k++) begin
        evidence_q[k] = '0;
        seen_q[k]     = 1'b0;
      end
      elapsed_q = '0;
      done_q    = 1'b0;
    end
    if (!done_q) begin
      theta_eff = theta_q;
      if (theta_eff > ONE_Q12) theta_eff = ONE_Q12;
      seen_q[w.fixated_item] = 1'b1;
      for (k = 0; k < ITEMS; k++) begin
        if (seen_q[k]) begin
          drift = rate_q[k];
          if (k != w.fixated_item) drift = round_q12(drift * theta_eff);
          noise = round_q12(longint'(noise_scale_q) * smp[k]);
          acc = evidence_q[k] + drift + noise;
          if (acc > EV_HI) acc = EV_HI;
          if (acc < EV_LO) acc = EV_LO;
          evidence_q[k] = EV_W'(acc);
        end
      end
      acc = longint'(elapsed_q) + longint'(time_step_q);
      if (acc > ELAPSED_TOP) acc = ELAPSED_TOP;
      elapsed_q = ELAPSED_W'(acc);
      for (k = 0; k < ITEMS; k++) begin
        if (evidence_q[k] > evidence_q[leader_q]) leader_q = IDX_W'(k);
      end
      decided_now = lead_held();
      if (decided_now || elapsed_q > max_duration_q) done_q = 1'b1;
    end else begin
      decided_now = lead_held();
    end
    o.finished      = done_q;
    o.decided       = decided_now;
    o.choice        = leader_q;
    o.response_time = elapsed_q;
    race_expected.push_back(o);
  endtask

  // register write while no tick is in flight
  task automatic write_race_reg(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_RATE_0, REG_RATE_1, REG_RATE_2, REG_RATE_3: rate_q[idx[1:0]] = data;
      REG_THETA:        theta_q        = THETA_W'(data);
      REG_NOISE_SCALE:  noise_scale_q  = data;
      REG_TIME_STEP:    time_step_q    = STEP_W'(data);
      REG_MAX_DURATION: max_duration_q = MAXDUR_W'(data);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // offer one tick word, hold it until taken, then predict it
  task automatic send_tick(input in_word_t w);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 3);
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item       <= w;
    item_valid <= 1'b1;
    do @(posedge clk); while (!(item_valid && !item_stall));
    ticks_sent++;
    predict_tick(w);
  endtask

  // stop offering and wait for every pending result word
  task automatic drain_results();
    @(negedge clk);
    item_valid <= 1'b0;
    while (race_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic in_word_t make_tick(input bit start, input logic [FIX_W-1:0] fix,
                                         input logic signed [SAMPLE_W-1:0] n0, n1, n2, n3);
    in_word_t w;
    w.start_trial  = start;
    w.fixated_item = fix;
    w.noise_0      = n0;
    w.noise_1      = n1;
    w.noise_2      = n2;
    w.noise_3      = n3;
    return w;
  endfunction

  // mostly moderate noise, sometimes any 16 bit value
  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    if ($urandom_range(0, 7) == 0) return SAMPLE_W'($urandom);
    return SAMPLE_W'($urandom_range(0, 16383) - 8192);
  endfunction

  // reset configuration, race from the reset state
  task automatic test_reset_state();
    send_tick(make_tick(1'b0, 2'd0, SMP_MAX, SMP_MIN, 16'sd0, -16'sd1));
    send_tick(make_tick(1'b0, 2'd1, SMP_MIN, SMP_MAX, 16'sh5555, 16'sh2aaa));
    send_tick(make_tick(1'b0, 2'd2, 16'sd0, 16'sd0, SMP_MAX, SMP_MIN));
    send_tick(make_tick(1'b0, 2'd3, -16'sd1, 16'sd1, SMP_MIN, SMP_MAX));
    drain_results();
  endtask

  // extreme rates, theta above one, immediate decision and frozen ticks
  task automatic test_lead_and_freeze();
    write_race_reg(REG_RATE_0, RATE_MAX);
    write_race_reg(REG_RATE_1, RATE_MIN);
    write_race_reg(REG_RATE_2, 16'd4096);
    write_race_reg(REG_RATE_3, 16'hffff);
    write_race_reg(REG_THETA, 16'd8191);
    write_race_reg(REG_NOISE_SCALE, 16'd4096);
    write_race_reg(REG_TIME_STEP, 16'd1000);
    write_race_reg(REG_MAX_DURATION, 16'hffff);
    write_race_reg(REG_UNUSED, 16'hffff);
    send_tick(make_tick(1'b1, 2'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_tick(make_tick(1'b0, 2'd2, SMP_MAX, SMP_MIN, SMP_MAX, SMP_MIN));
    send_tick(make_tick(1'b1, 2'd1, SMP_MIN, SMP_MAX, 16'sd0, 16'sd0));
    send_tick(make_tick(1'b0, 2'd3, 16'sd100, -16'sd100, SMP_MAX, SMP_MIN));
    send_tick(make_tick(1'b0, 2'd2, -16'sd4096, 16'sd4096, 16'sd0, 16'sd1));
    send_tick(make_tick(1'b0, 2'd0, 16'sd0, 16'sd0, SMP_MIN, SMP_MAX));
    drain_results();
  endtask

  // timeout at zero duration and after a few steps, theta zero
  task automatic test_timeout_and_step();
    write_race_reg(REG_THETA, 16'd0);
    write_race_reg(REG_NOISE_SCALE, 16'd0);
    write_race_reg(REG_MAX_DURATION, 16'd0);
    write_race_reg(REG_TIME_STEP, 16'd1023);
    send_tick(make_tick(1'b1, 2'd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_tick(make_tick(1'b0, 2'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    drain_results();
    write_race_reg(REG_MAX_DURATION, 16'd2500);
    write_race_reg(REG_TIME_STEP, 16'd1000);
    send_tick(make_tick(1'b1, 2'd3, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_tick(make_tick(1'b0, 2'd3, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_tick(make_tick(1'b0, 2'd3, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_tick(make_tick(1'b0, 2'd2, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    drain_results();
  endtask

  // tie at the top, leader change, lead just under and exactly at one
  task automatic test_tie_at_top();
    write_race_reg(REG_RATE_0, 16'd0);
    write_race_reg(REG_RATE_1, 16'd0);
    write_race_reg(REG_RATE_2, 16'd0);
    write_race_reg(REG_RATE_3, 16'd0);
    write_race_reg(REG_THETA, 16'd4096);
    write_race_reg(REG_NOISE_SCALE, 16'd4096);
    write_race_reg(REG_TIME_STEP, 16'd10);
    write_race_reg(REG_MAX_DURATION, 16'hffff);
    send_tick(make_tick(1'b1, 2'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_tick(make_tick(1'b0, 2'd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_tick(make_tick(1'b0, 2'd2, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_tick(make_tick(1'b0, 2'd3, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_tick(make_tick(1'b0, 2'd0, 16'sd8192, 16'sd8192, 16'sd0, 16'sd0));
    send_tick(make_tick(1'b0, 2'd1, 16'sd0, 16'sd4095, 16'sd0, 16'sd0));
    send_tick(make_tick(1'b0, 2'd1, 16'sd0, 16'sd1, 16'sd0, 16'sd0));
    send_tick(make_tick(1'b0, 2'd2, SMP_MAX, SMP_MIN, 16'sd0, 16'sd0));
    drain_results();
  endtask

  // two items climb at the steepest slope in a tie, two fall at the steepest slope
  task automatic test_saturation();
    int k;
    write_race_reg(REG_TIME_STEP, 16'd0);
    write_race_reg(REG_NOISE_SCALE, 16'd0);
    for (k = 0; k < ITEMS; k++)
      send_tick(make_tick(k == 0, FIX_W'(k), 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    drain_results();
    write_race_reg(REG_RATE_0, RATE_MAX);
    write_race_reg(REG_RATE_1, RATE_MAX);
    write_race_reg(REG_RATE_2, RATE_MIN);
    write_race_reg(REG_RATE_3, RATE_MIN);
    write_race_reg(REG_NOISE_SCALE, 16'hffff);
    for (k = 0; k < SAT_TICKS; k++)
      send_tick(make_tick(1'b0, FIX_W'(k), SMP_MAX, SMP_MAX, SMP_MIN, SMP_MIN));
    drain_results();
  endtask

  // hold the result side for a long stretch while ticks keep coming
  task automatic test_backpressure();
    int k;
    write_race_reg(REG_TIME_STEP, 16'd1);
    write_race_reg(REG_NOISE_SCALE, 16'd2048);
    hold_cycles = 60;
    for (k = 0; k < 24; k++)
      send_tick(make_tick(k == 0, FIX_W'($urandom_range(0, 3)), random_sample(),
                          random_sample(), random_sample(), random_sample()));
    drain_results();
  endtask

  task automatic randomize_config();
    int k;
    for (k = 0; k < RATE_REGS; k++) begin
      if ($urandom_range(0, 3) == 0)
        write_race_reg(REG_RATE_0 + CFG_INDEX_W'(k), CFG_DATA_W'($urandom));
      else
        write_race_reg(REG_RATE_0 + CFG_INDEX_W'(k),
                       CFG_DATA_W'($urandom_range(0, 12000) - 6000));
    end
    case ($urandom_range(0, 3))
      0:       write_race_reg(REG_THETA, 16'd0);
      1:       write_race_reg(REG_THETA, 16'd4096);
      2:       write_race_reg(REG_THETA, CFG_DATA_W'($urandom_range(4097, 8191)));
      default: write_race_reg(REG_THETA, CFG_DATA_W'($urandom_range(0, 4096)));
    endcase
    if ($urandom_range(0, 5) == 0)
      write_race_reg(REG_NOISE_SCALE, CFG_DATA_W'($urandom));
    else
      write_race_reg(REG_NOISE_SCALE, CFG_DATA_W'($urandom_range(0, 8192)));
    case ($urandom_range(0, 9))
      0:       write_race_reg(REG_TIME_STEP, 16'd0);
      1:       write_race_reg(REG_TIME_STEP, 16'd1023);
      default: write_race_reg(REG_TIME_STEP, CFG_DATA_W'($urandom_range(1, 1000)));
    endcase
    if ($urandom_range(0, 7) == 0)
      write_race_reg(REG_MAX_DURATION, CFG_DATA_W'($urandom));
    else
      write_race_reg(REG_MAX_DURATION, CFG_DATA_W'($urandom_range(0, 20000)));
  endtask

  // random trials: start tick, then sticky fixations; a few stray start flags
  task automatic test_random_race(input int phases, input int ticks_per_phase);
    int p, sent, trial_len, k;
    logic [FIX_W-1:0] fix;
    in_word_t w;
    for (p = 0; p < phases; p++) begin
      randomize_config();
      sent = 0;
      while (sent < ticks_per_phase) begin
        trial_len = $urandom_range(1, 30);
        fix = FIX_W'($urandom_range(0, 3));
        for (k = 0; k < trial_len && sent < ticks_per_phase; k++) begin
          if ($urandom_range(0, 3) == 0) fix = FIX_W'($urandom_range(0, 3));
          w = make_tick(k == 0, fix, random_sample(), random_sample(),
                        random_sample(), random_sample());
          if ($urandom_range(0, 19) == 0) w.start_trial = 1'($urandom_range(0, 1));
          send_tick(w);
          sent++;
        end
      end
      drain_results();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_lead_and_freeze();
    test_timeout_and_step();
    test_tie_at_top();
    test_saturation();
    test_backpressure();
    test_random_race(8, 70);
    // closing stretch without any idling
    idle_on = 1'b0;
    test_random_race(2, 55);

    $display("race run: %0d ticks in %0d trials, %0d result words compared",
             ticks_sent, trials_started, results_checked);
    $display("input held off %0d cycles; extreme rates, timeouts, ties and frozen trials included",
             held_off_cycles);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
